[design/nrmc_pkg.sv]
// Package: constants, types and helpers for the RMC sentence parser.
`timescale 1ns / 1ps
package nrmc_pkg;

  // Fraction digits kept for minutes and for speed
  localparam int MINUTE_FRAC_DIGITS = 4;
  localparam int SPEED_FRAC_DIGITS  = 2;

  // Store widths
  localparam int LAT_RAW_W = 27;
  localparam int LON_RAW_W = 30;
  localparam int SPEED_W   = 24;
  localparam int TIME_W    = 20;
  localparam int MILLIS_W  = 10;
  localparam int DATE_W    = 20;
  localparam int LAT_OUT_W = 30;
  localparam int LON_OUT_W = 34;
  localparam int LAT_DEG_W = 7;
  localparam int LON_DEG_W = 10;
  localparam int MINS_W    = 20;
  localparam int MSCL_W    = 26;

  // Characters
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_A     = 8'h41;
  localparam logic [7:0] CHR_S     = 8'h53;
  localparam logic [7:0] CHR_W     = 8'h57;

  // Header matching
  localparam logic [2:0] HDR_DONE = 3'd7;

  // Field indexes
  localparam logic [3:0] FLD_TIME   = 4'd0;
  localparam logic [3:0] FLD_STATUS = 4'd1;
  localparam logic [3:0] FLD_LAT    = 4'd2;
  localparam logic [3:0] FLD_NS     = 4'd3;
  localparam logic [3:0] FLD_LON    = 4'd4;
  localparam logic [3:0] FLD_EW     = 4'd5;
  localparam logic [3:0] FLD_SPEED  = 4'd6;
  localparam logic [3:0] FLD_DATE   = 4'd8;
  localparam logic [3:0] FLD_SKIP   = 4'd15;

  // Integer and fraction digit limits
  localparam logic [3:0] TIME_ILIM  = 4'd6;
  localparam logic [3:0] MILLI_FLIM = 4'd3;
  localparam logic [3:0] LAT_ILIM   = 4'd4;
  localparam logic [3:0] LON_ILIM   = 4'd5;
  localparam logic [3:0] POS_FLIM   = 4'(MINUTE_FRAC_DIGITS);
  localparam logic [3:0] SPD_ILIM   = 4'(7 - SPEED_FRAC_DIGITS);
  localparam logic [3:0] SPD_FLIM   = 4'(SPEED_FRAC_DIGITS);
  localparam logic [3:0] DATE_ILIM  = 4'd6;

  // Degree split: raw / (100 * 10^MINUTE_FRAC_DIGITS) by reciprocal
  localparam longint unsigned POS_UNIT  = 64'(10 ** MINUTE_FRAC_DIGITS);
  localparam longint unsigned DEG_DIV   = 64'd100 * POS_UNIT;
  localparam int              DEG_SHIFT = 50;
  localparam longint unsigned DEG_RECIP =
    ((64'd1 << DEG_SHIFT) + DEG_DIV - 64'd1) / DEG_DIV;
  localparam longint unsigned E7        = 64'd10000000;

  // Minutes to degrees: mins * 1e7 / (60 * unit) reduces to mins * 50 / 3
  localparam longint unsigned MIN_NUM   = 64'd50;
  localparam int              DIV3_SHIFT = 27;
  localparam longint unsigned DIV3_RECIP = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;

  // Result word carried down the conversion stages
  typedef struct packed {
    logic                fix_active;
    logic                lat_south;
    logic                lon_west;
    logic [SPEED_W-1:0]  speed;
    logic [TIME_W-1:0]   hhmmss;
    logic [MILLIS_W-1:0] millis;
    logic [DATE_W-1:0]   date;
    logic                format_error;
  } res_t;

  // Expected header character at each match position
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      3'd6:    ch = CHR_COMMA;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Power of ten for fraction padding
  function automatic logic [15:0] pow10(input logic [3:0] n);
    logic [15:0] p;
    unique case (n)
      4'd0:    p = 16'd1;
      4'd1:    p = 16'd10;
      4'd2:    p = 16'd100;
      4'd3:    p = 16'd1000;
      4'd4:    p = 16'd10000;
      default: p = 16'd1;
    endcase
    return p;
  endfunction

  // Shift in one decimal digit
  function automatic logic [31:0] dec_push(input logic [31:0] x, input logic [3:0] d);
    return (x << 3) + (x << 1) + 32'(d);
  endfunction

endpackage

[design/nmea_rmc_position_parser.sv]
// Top level: byte-wise RMC sentence parser with a pipelined position conversion.
//
//  channel | ports                          | dir | word
//  --------+--------------------------------+-----+------------------------------
//  in      | in_valid, in_ready, in_rx_byte | in  | one received character
//  out     | out_valid, out_ready, out_*    | out | one parsed RMC line
//
// One byte is taken every cycle while the result register is free or being read.
// A line's result passes the capture, degree split, minute scaling and divide-by-three
// stages after its newline is taken.
// A stalled result holds every stage and the input; reset clears all line state.
`timescale 1ns / 1ps
module nmea_rmc_position_parser
  import nrmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_fix_active,
  output logic [LAT_OUT_W-1:0] out_lat_deg_e7,
  output logic                 out_lat_south,
  output logic [LON_OUT_W-1:0] out_lon_deg_e7,
  output logic                 out_lon_west,
  output logic [SPEED_W-1:0]   out_speed_centiknots,
  output logic [TIME_W-1:0]    out_utc_hhmmss,
  output logic [MILLIS_W-1:0]  out_utc_millis,
  output logic [DATE_W-1:0]    out_date_ddmmyy,
  output logic                 out_format_error
);

  // Parser state
  logic [2:0]           hmp_r, hmp_nxt;
  logic                 rmc_r, rmc_nxt;
  logic [3:0]           fi_r, fi_nxt;
  logic                 frac_r, frac_nxt;
  logic [3:0]           dc_r, dc_nxt;
  logic [LAT_RAW_W-1:0] lat_r, lat_nxt;
  logic [LON_RAW_W-1:0] lon_r, lon_nxt;
  logic [SPEED_W-1:0]   spd_r, spd_nxt;
  logic [TIME_W-1:0]    tim_r, tim_nxt;
  logic [MILLIS_W-1:0]  ms_r, ms_nxt;
  logic [DATE_W-1:0]    date_r, date_nxt;
  logic [2:0]           flg_r, flg_nxt;
  logic                 err_r, err_nxt;

  logic       adv, in_acc, launch;
  logic [7:0] c;
  logic [3:0] dig, have;
  logic       is_digit;

  // Closed (fraction padded) values of the current field
  logic [LAT_RAW_W-1:0] lat_cl;
  logic [LON_RAW_W-1:0] lon_cl;
  logic [SPEED_W-1:0]   spd_cl;
  logic [MILLIS_W-1:0]  ms_cl;
  logic [3:0]           pos_sh, spd_sh, ms_sh;
  logic [63:0]          lat_pad, lon_pad, spd_pad, ms_pad;

  // Stages of the conversion
  logic                 va_r, vb_r, vc_r, out_valid_r;
  res_t                 res_a_r, res_b_r, res_c_r, res_o_r;
  logic [LAT_RAW_W-1:0] lat_a_r, lat_b_r;
  logic [LON_RAW_W-1:0] lon_a_r, lon_b_r;
  logic [LAT_DEG_W-1:0] latd_b_r;
  logic [LON_DEG_W-1:0] lond_b_r;
  logic [LAT_OUT_W-1:0] late7_c_r, lat_o_r;
  logic [LON_OUT_W-1:0] lone7_c_r, lon_o_r;
  logic [MSCL_W-1:0]    laty_c_r, lony_c_r;
  logic [63:0]          latq_prod, lonq_prod, latd_prod, lond_prod;
  logic [MINS_W-1:0]    lat_mins, lon_mins;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_acc   = in_valid && adv;
  assign c        = in_rx_byte;
  assign is_digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
  assign dig      = 4'(c - CHR_ZERO);

  // Pad the open fraction of the current field
  always_comb begin
    have    = frac_r ? dc_r : 4'd0;
    pos_sh  = (have > POS_FLIM)   ? 4'd0 : POS_FLIM - have;
    spd_sh  = (have > SPD_FLIM)   ? 4'd0 : SPD_FLIM - have;
    ms_sh   = (have > MILLI_FLIM) ? 4'd0 : MILLI_FLIM - have;
    lat_pad = 64'(lat_r) * 64'(pow10(pos_sh));
    lon_pad = 64'(lon_r) * 64'(pow10(pos_sh));
    spd_pad = 64'(spd_r) * 64'(pow10(spd_sh));
    ms_pad  = 64'(ms_r)  * 64'(pow10(ms_sh));
    lat_cl  = (fi_r == FLD_LAT)   ? lat_pad[LAT_RAW_W-1:0] : lat_r;
    lon_cl  = (fi_r == FLD_LON)   ? lon_pad[LON_RAW_W-1:0] : lon_r;
    spd_cl  = (fi_r == FLD_SPEED) ? spd_pad[SPEED_W-1:0]   : spd_r;
    ms_cl   = (fi_r == FLD_TIME)  ? ms_pad[MILLIS_W-1:0]   : ms_r;
  end

  // Parse one byte
  always_comb begin
    logic [3:0] ilim, flim;
    hmp_nxt  = hmp_r;
    rmc_nxt  = rmc_r;
    fi_nxt   = fi_r;
    frac_nxt = frac_r;
    dc_nxt   = dc_r;
    lat_nxt  = lat_r;
    lon_nxt  = lon_r;
    spd_nxt  = spd_r;
    tim_nxt  = tim_r;
    ms_nxt   = ms_r;
    date_nxt = date_r;
    flg_nxt  = flg_r;
    err_nxt  = err_r;
    launch   = 1'b0;
    unique case (fi_r)
      FLD_TIME:  begin ilim = TIME_ILIM; flim = MILLI_FLIM; end
      FLD_LAT:   begin ilim = LAT_ILIM;  flim = POS_FLIM;   end
      FLD_LON:   begin ilim = LON_ILIM;  flim = POS_FLIM;   end
      FLD_SPEED: begin ilim = SPD_ILIM;  flim = SPD_FLIM;   end
      default:   begin ilim = DATE_ILIM; flim = 4'd0;       end
    endcase
    if (in_acc) begin
      priority if (c == CHR_CR) begin
        // ignore carriage return
      end else if (c == CHR_LF) begin
        // close the line and clear everything
        launch   = rmc_r;
        hmp_nxt  = '0;
        rmc_nxt  = 1'b0;
        fi_nxt   = '0;
        frac_nxt = 1'b0;
        dc_nxt   = '0;
        lat_nxt  = '0;
        lon_nxt  = '0;
        spd_nxt  = '0;
        tim_nxt  = '0;
        ms_nxt   = '0;
        date_nxt = '0;
        flg_nxt  = '0;
        err_nxt  = 1'b0;
      end else if (!rmc_r) begin
        // match the header
        if (hmp_r != HDR_DONE && c == hdr_char(hmp_r)) begin
          hmp_nxt = hmp_r + 3'd1;
          rmc_nxt = (hmp_r == 3'd6);
        end else begin
          hmp_nxt = HDR_DONE;
        end
      end else if (fi_r != FLD_SKIP) begin
        if (c == CHR_COMMA || c == CHR_STAR) begin
          lat_nxt  = lat_cl;
          lon_nxt  = lon_cl;
          spd_nxt  = spd_cl;
          ms_nxt   = ms_cl;
          frac_nxt = 1'b0;
          dc_nxt   = '0;
          fi_nxt   = (c == CHR_COMMA) ? fi_r + 4'd1 : FLD_SKIP;
        end else if (fi_r == FLD_STATUS) begin
          flg_nxt[0] = (c == CHR_A);
        end else if (fi_r == FLD_NS) begin
          flg_nxt[1] = (c == CHR_S);
        end else if (fi_r == FLD_EW) begin
          flg_nxt[2] = (c == CHR_W);
        end else if (fi_r == FLD_TIME || fi_r == FLD_LAT || fi_r == FLD_LON ||
                     fi_r == FLD_SPEED || fi_r == FLD_DATE) begin
          // numeric field
          if (is_digit) begin
            if (!frac_r) begin
              if (dc_r >= ilim) begin
                err_nxt = 1'b1;
              end else begin
                dc_nxt = dc_r + 4'd1;
                unique case (fi_r)
                  FLD_TIME:  tim_nxt  = TIME_W'(dec_push(32'(tim_r), dig));
                  FLD_LAT:   lat_nxt  = LAT_RAW_W'(dec_push(32'(lat_r), dig));
                  FLD_LON:   lon_nxt  = LON_RAW_W'(dec_push(32'(lon_r), dig));
                  FLD_SPEED: spd_nxt  = SPEED_W'(dec_push(32'(spd_r), dig));
                  default:   date_nxt = DATE_W'(dec_push(32'(date_r), dig));
                endcase
              end
            end else if (dc_r < flim) begin
              dc_nxt = dc_r + 4'd1;
              unique case (fi_r)
                FLD_TIME: ms_nxt  = MILLIS_W'(dec_push(32'(ms_r), dig));
                FLD_LAT:  lat_nxt = LAT_RAW_W'(dec_push(32'(lat_r), dig));
                FLD_LON:  lon_nxt = LON_RAW_W'(dec_push(32'(lon_r), dig));
                default:  spd_nxt = SPEED_W'(dec_push(32'(spd_r), dig));
              endcase
            end
          end else if (c == CHR_DOT && fi_r != FLD_DATE && !frac_r) begin
            frac_nxt = 1'b1;
            dc_nxt   = '0;
          end else begin
            err_nxt = 1'b1;
          end
        end
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmp_r  <= '0;
      rmc_r  <= 1'b0;
      fi_r   <= '0;
      frac_r <= 1'b0;
      dc_r   <= '0;
      lat_r  <= '0;
      lon_r  <= '0;
      spd_r  <= '0;
      tim_r  <= '0;
      ms_r   <= '0;
      date_r <= '0;
      flg_r  <= '0;
      err_r  <= 1'b0;
    end else begin
      hmp_r  <= hmp_nxt;
      rmc_r  <= rmc_nxt;
      fi_r   <= fi_nxt;
      frac_r <= frac_nxt;
      dc_r   <= dc_nxt;
      lat_r  <= lat_nxt;
      lon_r  <= lon_nxt;
      spd_r  <= spd_nxt;
      tim_r  <= tim_nxt;
      ms_r   <= ms_nxt;
      date_r <= date_nxt;
      flg_r  <= flg_nxt;
      err_r  <= err_nxt;
    end
  end

  // Conversion arithmetic
  always_comb begin
    latd_prod = 64'(lat_a_r) * DEG_RECIP;
    lond_prod = 64'(lon_a_r) * DEG_RECIP;
    lat_mins  = MINS_W'(64'(lat_b_r) - 64'(latd_b_r) * DEG_DIV);
    lon_mins  = MINS_W'(64'(lon_b_r) - 64'(lond_b_r) * DEG_DIV);
    latq_prod = 64'(laty_c_r) * DIV3_RECIP;
    lonq_prod = 64'(lony_c_r) * DIV3_RECIP;
  end

  // Advance the conversion stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      va_r        <= launch;
      vb_r        <= va_r;
      vc_r        <= vb_r;
      out_valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_a_r.fix_active   <= flg_r[0];
      res_a_r.lat_south    <= flg_r[1];
      res_a_r.lon_west     <= flg_r[2];
      res_a_r.speed        <= spd_cl;
      res_a_r.hhmmss       <= tim_r;
      res_a_r.millis       <= ms_cl;
      res_a_r.date         <= date_r;
      res_a_r.format_error <= err_r;
      lat_a_r              <= lat_cl;
      lon_a_r              <= lon_cl;
      // split off whole degrees
      res_b_r  <= res_a_r;
      lat_b_r  <= lat_a_r;
      lon_b_r  <= lon_a_r;
      latd_b_r <= latd_prod[DEG_SHIFT +: LAT_DEG_W];
      lond_b_r <= lond_prod[DEG_SHIFT +: LON_DEG_W];
      // scale minutes and degrees
      res_c_r   <= res_b_r;
      laty_c_r  <= MSCL_W'(64'(lat_mins) * MIN_NUM);
      lony_c_r  <= MSCL_W'(64'(lon_mins) * MIN_NUM);
      late7_c_r <= LAT_OUT_W'(64'(latd_b_r) * E7);
      lone7_c_r <= LON_OUT_W'(64'(lond_b_r) * E7);
      // divide by three and sum
      res_o_r <= res_c_r;
      lat_o_r <= late7_c_r + LAT_OUT_W'(latq_prod >> DIV3_SHIFT);
      lon_o_r <= lone7_c_r + LON_OUT_W'(lonq_prod >> DIV3_SHIFT);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_fix_active       = res_o_r.fix_active;
  assign out_lat_deg_e7       = lat_o_r;
  assign out_lat_south        = res_o_r.lat_south;
  assign out_lon_deg_e7       = lon_o_r;
  assign out_lon_west         = res_o_r.lon_west;
  assign out_speed_centiknots = res_o_r.speed;
  assign out_utc_hhmmss       = res_o_r.hhmmss;
  assign out_utc_millis       = res_o_r.millis;
  assign out_date_ddmmyy      = res_o_r.date;
  assign out_format_error     = res_o_r.format_error;

`ifndef SYNTHESIS
  // a parsed line implies a complete header
  a_rmc_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    rmc_r |-> hmp_r == HDR_DONE)
    else $error("line flagged as RMC without full header");

  // no field progress outside an RMC line
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !rmc_r |-> (fi_r == FLD_TIME && !frac_r && dc_r == 4'd0))
    else $error("field state moved outside an RMC line");

  // fractions only open in fractional numeric fields
  a_frac_field: assert property (@(posedge clk) disable iff (!rst_n)
    frac_r |-> (fi_r == FLD_TIME || fi_r == FLD_LAT || fi_r == FLD_LON ||
                fi_r == FLD_SPEED))
    else $error("fraction open in a non-fractional field");

  // digit count never passes the longest integer part
  a_dc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dc_r <= 4'd6)
    else $error("digit count out of range");

  // a newline of an RMC line reaches the last conversion stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (launch && in_acc && out_ready) |=> ##2 (vc_r || out_valid_r) )
    else $error("launched line lost in conversion");
`endif

endmodule

[tb/sv/nmea_rmc_position_parser_tb.sv]
// Testbench for the RMC sentence parser: byte stream stimulus, line predictor, scoreboard.
`timescale 1ns / 1ps
module nmea_rmc_position_parser_tb;
  import nrmc_pkg::*;

  // One parsed line as the block should report it
  typedef struct {
    bit        fix;
    bit [29:0] lat;
    bit        south;
    bit [33:0] lon;
    bit        west;
    bit [23:0] speed;
    bit [19:0] hms;
    bit [9:0]  millis;
    bit [19:0] date;
    bit        ferr;
  } fix_rec_t;

  // Scoreboard: runs the line parser model and checks reported fixes
  class fix_scoreboard;
    fix_rec_t pending[$];
    int       errors;
    int       lines_seen;
    bit [2:0] hdr_pos;
    bit       is_rmc;
    bit [3:0] fld;
    bit       in_frac;
    bit [3:0] ndig;
    longint unsigned lat_acc, lon_acc, spd_acc, time_acc, ms_acc, date_acc;
    bit [2:0] flags;
    bit       err;

    function void clear_line();
      hdr_pos = 0; is_rmc = 0; fld = 0; in_frac = 0; ndig = 0;
      lat_acc = 0; lon_acc = 0; spd_acc = 0; time_acc = 0; ms_acc = 0;
      date_acc = 0; flags = 0; err = 0;
    endfunction

    function longint unsigned pad(longint unsigned v, int want);
      int have;
      have = in_frac ? ndig : 0;
      if (have > want) have = want;
      for (int i = have; i < want; i++) v = v * 10;
      return v;
    endfunction

    function void end_field();
      case (fld)
        FLD_TIME:  ms_acc  = pad(ms_acc, 3);
        FLD_LAT:   lat_acc = pad(lat_acc, MINUTE_FRAC_DIGITS);
        FLD_LON:   lon_acc = pad(lon_acc, MINUTE_FRAC_DIGITS);
        FLD_SPEED: spd_acc = pad(spd_acc, SPEED_FRAC_DIGITS);
        default: ;
      endcase
      in_frac = 0; ndig = 0;
    endfunction

    function void push_digit(ref longint unsigned acc, input bit [7:0] c);
      acc = acc * 10 + (c - CHR_ZERO);
      ndig++;
    endfunction

    function void numeric(bit [7:0] c);
      int ilim, flim;
      case (fld)
        FLD_TIME:  begin ilim = 6; flim = 3; end
        FLD_LAT:   begin ilim = 4; flim = MINUTE_FRAC_DIGITS; end
        FLD_LON:   begin ilim = 5; flim = MINUTE_FRAC_DIGITS; end
        FLD_SPEED: begin ilim = 7 - SPEED_FRAC_DIGITS; flim = SPEED_FRAC_DIGITS; end
        default:   begin ilim = 6; flim = 0; end
      endcase
      if (c >= CHR_ZERO && c <= CHR_NINE) begin
        if (!in_frac && ndig >= ilim) begin
          err = 1;
          return;
        end
        if (in_frac && ndig >= flim) return;
        case (fld)
          FLD_TIME: if (in_frac) push_digit(ms_acc, c); else push_digit(time_acc, c);
          FLD_LAT:   push_digit(lat_acc, c);
          FLD_LON:   push_digit(lon_acc, c);
          FLD_SPEED: push_digit(spd_acc, c);
          default:   push_digit(date_acc, c);
        endcase
      end else if (c == CHR_DOT && fld != FLD_DATE && !in_frac) begin
        in_frac = 1; ndig = 0;
      end else begin
        err = 1;
      end
    endfunction

    function longint unsigned deg_e7(longint unsigned raw);
      longint unsigned u;
      u = 1;
      for (int i = 0; i < MINUTE_FRAC_DIGITS; i++) u = u * 10;
      return (raw / (100 * u)) * 64'd10000000 + ((raw % (100 * u)) * 64'd10000000) / (60 * u);
    endfunction

    // Note an accepted byte; queue a fix when an RMC line ends
    function void note_byte(bit [7:0] c);
      fix_rec_t r;
      if (c == CHR_CR) return;
      if (c == CHR_LF) begin
        if (is_rmc) begin
          end_field();
          r.fix = flags[0]; r.south = flags[1]; r.west = flags[2];
          r.lat = 30'(deg_e7(lat_acc)); r.lon = 34'(deg_e7(lon_acc));
          r.speed = 24'(spd_acc); r.hms = 20'(time_acc); r.millis = 10'(ms_acc);
          r.date = 20'(date_acc); r.ferr = err;
          pending.push_back(r);
        end
        clear_line();
        return;
      end
      if (!is_rmc) begin
        if (hdr_pos < 7 && c == hdr_char(hdr_pos)) begin
          hdr_pos++;
          if (hdr_pos == HDR_DONE) is_rmc = 1;
        end else begin
          hdr_pos = HDR_DONE;
        end
        return;
      end
      if (fld == FLD_SKIP) return;
      if (c == CHR_COMMA) begin
        end_field(); fld++;
      end else if (c == CHR_STAR) begin
        end_field(); fld = FLD_SKIP;
      end else begin
        case (fld)
          FLD_TIME, FLD_LAT, FLD_LON, FLD_SPEED, FLD_DATE: numeric(c);
          FLD_STATUS: flags[0] = (c == CHR_A);
          FLD_NS:     flags[1] = (c == CHR_S);
          FLD_EW:     flags[2] = (c == CHR_W);
          default: ;
        endcase
      end
    endfunction

    function void cmp(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    // Check one reported fix against the oldest prediction
    function void check_fix(fix_rec_t a);
      fix_rec_t e;
      lines_seen++;
      if (pending.size() == 0) begin
        $error("fix reported with none pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("fix_active", e.fix, a.fix);
      cmp("lat_deg_e7", e.lat, a.lat);
      cmp("lat_south", e.south, a.south);
      cmp("lon_deg_e7", e.lon, a.lon);
      cmp("lon_west", e.west, a.west);
      cmp("speed_centiknots", e.speed, a.speed);
      cmp("utc_hhmmss", e.hms, a.hms);
      cmp("utc_millis", e.millis, a.millis);
      cmp("date_ddmmyy", e.date, a.date);
      cmp("format_error", e.ferr, a.ferr);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] in_rx_byte = 0;
  logic out_valid;
  logic out_ready = 0;
  logic out_fix_active, out_lat_south, out_lon_west, out_format_error;
  logic [LAT_OUT_W-1:0] out_lat_deg_e7;
  logic [LON_OUT_W-1:0] out_lon_deg_e7;
  logic [SPEED_W-1:0] out_speed_centiknots;
  logic [TIME_W-1:0] out_utc_hhmmss;
  logic [MILLIS_W-1:0] out_utc_millis;
  logic [DATE_W-1:0] out_date_ddmmyy;

  fix_scoreboard sb = new();
  bit quiet_tail = 0;
  bit hold_reader = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  nmea_rmc_position_parser i_dut (.*);

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    fix_rec_t a;
    if (rst_n && in_valid && in_ready) sb.note_byte(in_rx_byte);
    if (rst_n && out_valid && out_ready) begin
      a.fix = out_fix_active; a.lat = out_lat_deg_e7; a.south = out_lat_south;
      a.lon = out_lon_deg_e7; a.west = out_lon_west; a.speed = out_speed_centiknots;
      a.hms = out_utc_hhmmss; a.millis = out_utc_millis; a.date = out_date_ddmmyy;
      a.ferr = out_format_error;
      sb.check_fix(a);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_reader) begin
        out_ready <= 0;
        for (n = 0; n < 300; n++) @(negedge clk);
        hold_reader = 0;
      end
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  // Offer one byte and hold it until taken
  task automatic send_byte(bit [7:0] c);
    int gap;
    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_rx_byte <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
    return s;
  endfunction

  // Numeric field with random integer and fraction lengths, sometimes malformed
  function automatic string num_field(int ilim, int flim, bit dot_ok);
    string s;
    int k;
    k = $urandom_range(0, 19);
    s = digits($urandom_range(0, ilim));
    if (k == 0) s = digits($urandom_range(ilim + 1, ilim + 3));
    if (dot_ok && $urandom_range(0, 3) != 0) s = {s, ".", digits($urandom_range(0, flim + 2))};
    if (k == 1) s = {s, string'(8'($urandom_range(33, 126)))};
    if (k == 2) s = {s, "."};
    return s;
  endfunction

  function automatic string letter(string hit, string miss);
    case ($urandom_range(0, 3))
      0: return "";
      1: return miss;
      2: return string'(8'($urandom_range(65, 90)));
      default: return hit;
    endcase
  endfunction

  function automatic string rand_rmc();
    string s;
    s = {"$GPRMC,", num_field(6, 3, 1), ",", letter("A", "V"), ",",
         num_field(4, 4, 1), ",", letter("S", "N"), ",", num_field(5, 4, 1), ",",
         letter("W", "E"), ",", num_field(5, 2, 1), ",", digits(3), ".1,",
         num_field(6, 0, $urandom_range(0, 9) == 0)};
    case ($urandom_range(0, 3))
      0: s = {s, ",,,A*", digits(2)};
      1: s = {s, "*7F"};
      default: ;
    endcase
    return s;
  endfunction

  function automatic string noise_line();
    string s;
    s = ($urandom_range(0, 1)) ? "$GPGGA,1,2" : "$GPRM";
    repeat ($urandom_range(0, 8)) s = {s, string'(8'($urandom_range(0, 255)))};
    return s;
  endfunction

  initial begin
    string ln;
    sb.clear_line();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed lines: extremes, CR, empty fields, long digits, non-RMC lines
    send_line("$GPRMC,235959.999,A,8959.9999,S,17959.9999,W,99999.99,0,311299\r\n");
    send_line("$GPRMC,000000.000,V,0000.0000,N,00000.0000,E,0.00,0,000000\n");
    send_line("$GPRMC,,,,,,,,,\n");
    send_line("$GPRMC,\n");
    send_line("$GP\rRMC,12\r34,A\n");
    send_line("$GPRMC,1234567.12345,A,99999.99999,S,999999.99999,W,123456.789,,1.2\n");
    send_line("$GPRMC,12x,AB,9960.5,SX,12.3.4,WW,.5,1,010203*55,9\n");
    send_line("$GPGGA,1,2,3\n");
    send_line("GPRMC,1,A\n");
    send_byte(8'hFF); send_byte(8'h00); send_byte(CHR_LF);
    send_line("$GPRMC,1,A,1,S,1,W,1,1,1,1,1,1,1,1,1,1,1,1\n");

    // Long receiver hold-off while lines keep coming
    hold_reader = 1;
    repeat (6) send_line("$GPRMC,1,A,4807.038,N,01131.000,E,22.4,84.4,230394\n");

    // Random stream, mostly well-formed RMC lines
    while (bytes_sent < 1350) begin
      if (bytes_sent > 1100) quiet_tail = 1;
      if ($urandom_range(0, 5) == 0) ln = noise_line();
      else ln = rand_rmc();
      if ($urandom_range(0, 4) == 0) ln = {ln, "\r"};
      send_line({ln, "\n"});
    end
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d bytes and %0d fixes, with stalls on both sides.",
             bytes_sent, sb.lines_seen);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
